/* hw/rtl/gps_pkg.sv */
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants for the gravity pull position step block.
// ----------------------------------------------------------------------------
package gps_pkg;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_OWN_WEIGHT = 3'd0;
    localparam cfg_idx_t REG_GRAV_CONST = 3'd1;
    localparam cfg_idx_t REG_START_X    = 3'd2;
    localparam cfg_idx_t REG_START_Y    = 3'd3;
    localparam cfg_idx_t REG_START_Z    = 3'd4;

    localparam logic [31:0] WEIGHT_RST = 32'h0001_0000;
    localparam logic [31:0] GRAV_RST   = 32'h0001_0000;

    // Gap threshold of 32.0 in Q16.16
    localparam logic [32:0] GAP_MIN = 33'h0_0020_0000;
    // Intermediate saturation level 2^62-1
    localparam logic [61:0] SAT_CAP = {62{1'b1}};

    // Serial unit
    localparam int ALU_W = 80;
    localparam int REM_W = 52;
    typedef logic [6:0] iter_t;
    localparam iter_t ITER_MUL32 = 7'd32;
    localparam iter_t ITER_SQ    = 7'd25;
    localparam iter_t ITER_SQRT  = 7'd25;
    localparam iter_t ITER_DIVF  = 7'd78;
    localparam iter_t ITER_DIVU  = 7'd41;
    localparam iter_t ITER_MULMV = 7'd17;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
        iter_t   iters;
    } alu_req_t;

    // Position load from a start register write
    typedef struct packed {
        logic        en;
        cfg_idx_t    idx;
        logic [31:0] data;
    } pos_load_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MA,
        S_MB,
        S_GAP,
        S_SQ,
        S_RT,
        S_DF,
        S_DU,
        S_MV,
        S_UPD,
        S_DONE
    } seq_state_t;

endpackage

/* hw/rtl/gps_in_if.sv */
// ----------------------------------------------------------------------------
// gps_in_if
// Input channel: other body position and weight.
// ----------------------------------------------------------------------------
interface gps_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] other_z;
    logic        [31:0] other_weight;

    modport source (output valid, output other_x, output other_y, output other_z,
                    output other_weight, input ready);
    modport sink   (input valid, input other_x, input other_y, input other_z,
                    input other_weight, output ready);
endinterface

/* hw/rtl/gps_out_if.sv */
// ----------------------------------------------------------------------------
// gps_out_if
// Result channel: updated position and saturation flag.
// ----------------------------------------------------------------------------
interface gps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               saturated;

    modport source (output valid, output new_x, output new_y, output new_z,
                    output saturated, input ready);
    modport sink   (input valid, input new_x, input new_y, input new_z,
                    input saturated, output ready);
endinterface

/* hw/rtl/gravity_pull_position_step.sv */
// ----------------------------------------------------------------------------
// gravity_pull_position_step
// Gravitational pull step on one kept body position, axes x, y, z in turn.
// ----------------------------------------------------------------------------
// Steps: a force term, then a gap check per axis; a far axis also runs squares,
//   root, two divides and one multiply in the shared bit-serial unit.
// Throughput: one item at a time; the next is taken once the step ends, while
//   the previous result may still wait in the output register.
// Reset: position 0, weight and G 1.0; no clearing pass.
module gravity_pull_position_step
    import gps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_idx,
    input  logic [31:0] cfg_data,
    gps_in_if.sink      item,
    gps_out_if.source   result
);

    logic [31:0] own_weight_reg, own_weight_next;
    logic [31:0] grav_const_reg, grav_const_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic        out_sat_reg;

    logic        seq_idle, seq_done, start, res_free, sat;
    logic [31:0] pos_x, pos_y, pos_z;
    pos_load_t   load;

    assign start      = item.valid && item.ready;
    assign item.ready = seq_idle;
    assign res_free   = !out_valid_reg || result.ready;
    assign load.en    = cfg_we;
    assign load.idx   = cfg_idx;
    assign load.data  = cfg_data;

    gps_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .other_x      (item.other_x),
        .other_y      (item.other_y),
        .other_z      (item.other_z),
        .other_weight (item.other_weight),
        .own_weight   (own_weight_reg),
        .grav_const   (grav_const_reg),
        .load         (load),
        .res_free     (res_free),
        .idle         (seq_idle),
        .done         (seq_done),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .saturated    (sat)
    );

    // Configuration writes
    always_comb
    begin
        own_weight_next = own_weight_reg;
        grav_const_next = grav_const_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_OWN_WEIGHT: own_weight_next = cfg_data;
                REG_GRAV_CONST: grav_const_next = cfg_data;
                default:        own_weight_next = own_weight_reg;
            endcase
        end
    end

    // Hold a result until its transfer
    always_comb
    begin
        if (seq_done)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_weight_reg <= WEIGHT_RST;
            grav_const_reg <= GRAV_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            own_weight_reg <= own_weight_next;
            grav_const_reg <= grav_const_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            out_x_reg   <= pos_x;
            out_y_reg   <= pos_y;
            out_z_reg   <= pos_z;
            out_sat_reg <= sat;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.new_x     = out_x_reg;
    assign result.new_y     = out_y_reg;
    assign result.new_z     = out_z_reg;
    assign result.saturated = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before its transfer");
`endif

endmodule

/* hw/rtl/gps_serial_alu.sv */
// ----------------------------------------------------------------------------
// gps_serial_alu
// Shared bit-serial unit: shift-add multiply, restoring divide and
// square root, one bit (two radicand bits for the root) per cycle.
// ----------------------------------------------------------------------------
module gps_serial_alu
    import gps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    input  logic [ALU_W-1:0] opa,
    input  logic [ALU_W-1:0] opb,
    output logic             done,
    output logic [ALU_W-1:0] res
);

    logic [ALU_W-1:0] a_reg, a_next;
    logic [ALU_W-1:0] b_reg, b_next;
    logic [ALU_W-1:0] p_reg, p_next;
    logic [REM_W-1:0] r_reg, r_next;
    iter_t            cnt_reg, cnt_next;
    alu_op_t          op_reg, op_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [ALU_W-1:0] mul_sum;
    logic [REM_W-1:0] div_t;
    logic [REM_W-1:0] sq_t;
    logic [REM_W-1:0] sq_trial;

    // One step of each operation
    always_comb
    begin
        mul_sum  = {p_reg[ALU_W-2:0], 1'b0} + (b_reg[ALU_W-1] ? a_reg : '0);
        div_t    = {r_reg[REM_W-2:0], a_reg[ALU_W-1]};
        sq_t     = {r_reg[REM_W-3:0], a_reg[ALU_W-1:ALU_W-2]};
        sq_trial = {p_reg[REM_W-3:0], 2'b01};

        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.go)
        begin
            a_next    = opa;
            b_next    = opb;
            p_next    = '0;
            r_next    = '0;
            op_next   = req.op;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - iter_t'(1);
            busy_next = (cnt_reg != iter_t'(1));
            done_next = (cnt_reg == iter_t'(1));
            case (op_reg)
                ALU_MUL:
                begin
                    p_next = mul_sum;
                    b_next = {b_reg[ALU_W-2:0], 1'b0};
                end
                ALU_DIV:
                begin
                    a_next = {a_reg[ALU_W-2:0], 1'b0};
                    if (div_t >= b_reg[REM_W-1:0])
                    begin
                        r_next = div_t - b_reg[REM_W-1:0];
                        p_next = {p_reg[ALU_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = div_t;
                        p_next = {p_reg[ALU_W-2:0], 1'b0};
                    end
                end
                ALU_SQRT:
                begin
                    a_next = {a_reg[ALU_W-3:0], 2'b00};
                    if (sq_t >= sq_trial)
                    begin
                        r_next = sq_t - sq_trial;
                        p_next = {p_reg[ALU_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = sq_t;
                        p_next = {p_reg[ALU_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    p_next = p_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign res  = p_reg;

`ifndef NO_ASSERTIONS
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) req.go |-> !busy_reg)
        else $error("serial unit started while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("serial unit done while still iterating");
`endif

endmodule

/* hw/rtl/gps_seq.sv */
// ----------------------------------------------------------------------------
// gps_seq
// Step sequencer: holds the position, walks the axes and drives the
// shared serial unit through force, square, root, quotient and move terms.
// ----------------------------------------------------------------------------
module gps_seq
    import gps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] other_x,
    input  logic signed [31:0] other_y,
    input  logic signed [31:0] other_z,
    input  logic        [31:0] other_weight,
    input  logic        [31:0] own_weight,
    input  logic        [31:0] grav_const,
    input  pos_load_t          load,
    input  logic               res_free,
    output logic               idle,
    output logic               done,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic               saturated
);

    seq_state_t state_reg, state_next;
    logic [1:0]  k_reg, k_next;
    logic [1:0]  j_reg, j_next;
    logic        issued_reg, issued_next;
    logic        sat_reg, sat_next;
    logic        dir_reg, dir_next;
    logic [31:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [31:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next, w_reg, w_next;
    logic [47:0] a_reg, a_next;
    logic [61:0] b_reg, b_next;
    logic [24:0] g0_reg, g0_next, g1_reg, g1_next, g2_reg, g2_next;
    logic [49:0] r2_reg, r2_next;
    logic [24:0] rt_reg, rt_next;
    logic [51:0] f_reg, f_next;
    logic [16:0] u_reg, u_next;
    logic [52:0] mv_reg, mv_next;

    alu_req_t         req;
    logic [ALU_W-1:0] opa, opb, res;
    logic             alu_done;

    logic [32:0] dx, dy, dz, mx, my, mz;
    logic        far;
    logic [24:0] g8k;
    logic [31:0] posk;
    logic [54:0] pos_ext, mv_ext, nv;
    logic        ovf_hi, ovf_lo;
    logic [31:0] nv_sat;

    gps_serial_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .done  (alu_done),
        .res   (res)
    );

    // Gaps from the current, partly updated position
    always_comb
    begin
        dx  = {px_reg[31], px_reg} - {ox_reg[31], ox_reg};
        dy  = {py_reg[31], py_reg} - {oy_reg[31], oy_reg};
        dz  = {pz_reg[31], pz_reg} - {oz_reg[31], oz_reg};
        mx  = dx[32] ? (~dx + 33'd1) : dx;
        my  = dy[32] ? (~dy + 33'd1) : dy;
        mz  = dz[32] ? (~dz + 33'd1) : dz;
        far = (mx >= GAP_MIN) || (my >= GAP_MIN) || (mz >= GAP_MIN);
        case (k_reg)
            2'd0:    begin g8k = g0_reg; posk = px_reg; end
            2'd1:    begin g8k = g1_reg; posk = py_reg; end
            default: begin g8k = g2_reg; posk = pz_reg; end
        endcase
    end

    // Move and clamp to the signed 32-bit range
    always_comb
    begin
        pos_ext = {{23{posk[31]}}, posk};
        mv_ext  = {2'b00, mv_reg};
        nv      = dir_reg ? (pos_ext + mv_ext) : (pos_ext - mv_ext);
        ovf_hi  = !nv[54] && (nv[53:31] != '0);
        ovf_lo  = nv[54] && (nv[53:31] != '1);
        if (ovf_hi)
            nv_sat = 32'h7FFF_FFFF;
        else if (ovf_lo)
            nv_sat = 32'h8000_0000;
        else
            nv_sat = nv[31:0];
    end

    // Next state, serial unit requests and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        issued_next = issued_reg;
        sat_next    = sat_reg;
        dir_next    = dir_reg;
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg;
        ox_next = ox_reg; oy_next = oy_reg; oz_next = oz_reg; w_next = w_reg;
        a_next  = a_reg;  b_next  = b_reg;
        g0_next = g0_reg; g1_next = g1_reg; g2_next = g2_reg;
        r2_next = r2_reg; rt_next = rt_reg; f_next = f_reg; u_next = u_reg;
        mv_next = mv_reg;
        req.go    = 1'b0;
        req.op    = ALU_MUL;
        req.iters = ITER_MUL32;
        opa       = '0;
        opb       = '0;
        idle      = 1'b0;
        done      = 1'b0;

        // Pick the operation of the current state
        case (state_reg)
            S_MA:
            begin
                opa = {48'b0, own_weight};
                opb = {w_reg, 48'b0};
            end
            S_MB:
            begin
                opa = {32'b0, a_reg};
                opb = {grav_const, 48'b0};
            end
            S_SQ:
            begin
                req.iters = ITER_SQ;
                opa = {55'b0, g0_reg};
                opb = {g0_reg, 55'b0};
            end
            S_RT:
            begin
                req.op    = ALU_SQRT;
                req.iters = ITER_SQRT;
                opa = {r2_reg, 30'b0};
            end
            S_DF:
            begin
                req.op    = ALU_DIV;
                req.iters = ITER_DIVF;
                opa = {b_reg, 18'b0};
                opb = {30'b0, r2_reg};
            end
            S_DU:
            begin
                req.op    = ALU_DIV;
                req.iters = ITER_DIVU;
                opa = {g8k, 55'b0};
                opb = {55'b0, rt_reg};
            end
            S_MV:
            begin
                req.iters = ITER_MULMV;
                opa = {28'b0, f_reg};
                opb = {u_reg, 63'b0};
            end
            default:
            begin
                opa = '0;
            end
        endcase

        if (state_reg == S_MA || state_reg == S_MB || state_reg == S_SQ
            || state_reg == S_RT || state_reg == S_DF || state_reg == S_DU
            || state_reg == S_MV)
        begin
            req.go = !issued_reg;
            if (!issued_reg)
                issued_next = 1'b1;
            else if (alu_done)
                issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (load.en)
                begin
                    case (load.idx)
                        REG_START_X: px_next = load.data;
                        REG_START_Y: py_next = load.data;
                        REG_START_Z: pz_next = load.data;
                        default:     px_next = px_reg;
                    endcase
                end
                if (start)
                begin
                    ox_next    = other_x;
                    oy_next    = other_y;
                    oz_next    = other_z;
                    w_next     = other_weight;
                    k_next     = 2'd0;
                    sat_next   = 1'b0;
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                if (alu_done)
                begin
                    a_next     = res[63:16];
                    state_next = S_MB;
                end
            end
            S_MB:
            begin
                if (alu_done)
                begin
                    b_next     = (res[79:78] != 2'b00) ? SAT_CAP : res[77:16];
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                g0_next = mx[32:8];
                g1_next = my[32:8];
                g2_next = mz[32:8];
                case (k_reg)
                    2'd0:    dir_next = dx[32];
                    2'd1:    dir_next = dy[32];
                    default: dir_next = dz[32];
                endcase
                r2_next = '0;
                j_next  = 2'd0;
                if (far)
                    state_next = S_SQ;
                else if (k_reg == 2'd2)
                    state_next = S_DONE;
                else
                    k_next = k_reg + 2'd1;
            end
            S_SQ:
            begin
                // Accumulate squares, rotating the gaps back to axis order
                if (alu_done)
                begin
                    r2_next = r2_reg + res[49:0];
                    g0_next = g1_reg;
                    g1_next = g2_reg;
                    g2_next = g0_reg;
                    j_next  = j_reg + 2'd1;
                    if (j_reg == 2'd2)
                        state_next = S_RT;
                end
            end
            S_RT:
            begin
                if (alu_done)
                begin
                    rt_next    = res[24:0];
                    state_next = S_DF;
                end
            end
            S_DF:
            begin
                if (alu_done)
                begin
                    f_next     = res[51:0];
                    state_next = S_DU;
                end
            end
            S_DU:
            begin
                if (alu_done)
                begin
                    u_next     = res[16:0];
                    state_next = S_MV;
                end
            end
            S_MV:
            begin
                if (alu_done)
                begin
                    mv_next    = res[68:16];
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                case (k_reg)
                    2'd0:    px_next = nv_sat;
                    2'd1:    py_next = nv_sat;
                    default: pz_next = nv_sat;
                endcase
                sat_next = sat_reg | ovf_hi | ovf_lo;
                if (k_reg == 2'd2)
                    state_next = S_DONE;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_GAP;
                end
            end
            S_DONE:
            begin
                done = res_free;
                if (res_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            j_reg      <= '0;
            issued_reg <= 1'b0;
            sat_reg    <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            issued_reg <= issued_next;
            sat_reg    <= sat_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        dir_reg <= dir_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
        oz_reg  <= oz_next;
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        g0_reg  <= g0_next;
        g1_reg  <= g1_next;
        g2_reg  <= g2_next;
        r2_reg  <= r2_next;
        rt_reg  <= rt_next;
        f_reg   <= f_next;
        u_reg   <= u_next;
        mv_reg  <= mv_next;
    end

    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign pos_z     = pz_reg;
    assign saturated = sat_reg;

`ifndef NO_ASSERTIONS
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> issued_reg)
        else $error("serial unit finished with no request outstanding");
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> state_reg == S_MA)
        else $error("accepted item did not start a step");
`endif

endmodule
